// ===== hw/rtl/mmm_pkg.sv =====
package mmm_pkg;

   localparam int MotorLimit = 8;
   localparam int CoefFraction = 12;
   localparam int NumGeometries = 12;
   localparam int MaxRows = 8;
   localparam int MotorCountBits = 4;
   localparam int MotorIndexBits = 3;
   localparam int CoefBits = CoefFraction + 4;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_GEOMETRY = 3'd0;
   localparam logic [2:0] CSR_YAW_SIGN = 3'd1;
   localparam logic [2:0] CSR_FLOOR = 3'd2;
   localparam logic [2:0] CSR_CEILING = 3'd3;
   localparam logic [2:0] CSR_IDLE = 3'd4;
   localparam logic [2:0] CSR_CHECK = 3'd5;
   localparam logic [2:0] CSR_STOP = 3'd6;

   typedef struct packed {
      logic [11:0]        throttle_demand;
      logic signed [15:0] pitch_corr;
      logic signed [15:0] roll_corr;
      logic signed [15:0] yaw_corr;
      logic signed [11:0] yaw_stick;
      logic [11:0]        throttle_raw;
      logic               armed;
   } req_type;

   typedef struct packed {
      logic [2:0]         motor_number;
      logic signed [15:0] motor_level;
      logic               frame_end;
   } rsp_type;

   typedef struct packed {
      logic [3:0]         geometry;
      logic signed [1:0]  yaw_sign;
      logic [11:0]        throttle_floor;
      logic [11:0]        throttle_ceiling;
      logic [11:0]        idle_command;
      logic [11:0]        throttle_check;
      logic               stop_on_low;
   } cfg_type;

   // One classified frame handed from the front to the back.
   typedef struct packed {
      logic [MotorCountBits-1:0] count;
      logic [3:0]                geometry;
      logic [11:0]               thr;
      logic signed [15:0]        pitch;
      logic signed [15:0]        roll;
      logic signed [17:0]        yaw;
      logic                      low_stick;
      logic                      armed;
   } frame_type;

   // Decimal coefficient to fixed point, rounded half away from zero.
   function automatic logic signed [CoefBits-1:0] to_fixed(input int micro);
      longint mag;
      longint q;
      begin
         mag = (micro < 0) ? -longint'(micro) : longint'(micro);
         q = (mag * (longint'(1) <<< CoefFraction) + 500000) / 1000000;
         to_fixed = (micro < 0) ? CoefBits'(-q) : CoefBits'(q);
      end
   endfunction

   // Fixed point weights used by the frame tables.
   localparam logic signed [CoefBits-1:0] CoefZero = '0;
   localparam logic signed [CoefBits-1:0] CoefOne = to_fixed(1000000);
   localparam logic signed [CoefBits-1:0] CoefFourThirds = to_fixed(1333333);
   localparam logic signed [CoefBits-1:0] CoefMinusTwoThirds = to_fixed(-666667);
   localparam logic signed [CoefBits-1:0] CoefRoot3Half = to_fixed(866025);
   localparam logic signed [CoefBits-1:0] CoefRoot2Half = to_fixed(707107);
   localparam logic signed [CoefBits-1:0] CoefHalf = to_fixed(500000);
   localparam logic signed [CoefBits-1:0] CoefFiveQuarters = to_fixed(1250000);
   localparam logic signed [CoefBits-1:0] CoefThreeQuarters = to_fixed(750000);

   function automatic logic [MotorCountBits-1:0] table_count(input logic [3:0] g);
      int c;
      begin
         case (g)
            4'd0: c = 3;
            4'd1, 4'd2, 4'd5, 4'd10: c = 4;
            4'd3, 4'd4, 4'd6, 4'd11: c = 6;
            4'd7, 4'd8, 4'd9: c = 8;
            default: c = 0;
         endcase
         if (c > MotorLimit) c = MotorLimit;
         table_count = MotorCountBits'(c);
      end
   endfunction

   // Fixed point coefficient; sel 0 roll, 1 pitch, 2 yaw (throttle is one).
   function automatic logic signed [CoefBits-1:0] row_coef(input logic [3:0] g,
                                                          input logic [2:0] m,
                                                          input logic [1:0] sel);
      logic signed [CoefBits-1:0] r [3];
      begin
         r[0] = CoefZero; r[1] = CoefZero; r[2] = CoefZero;
         case ({g, m})
            {4'd0, 3'd0}: r = '{CoefZero, CoefFourThirds, CoefZero};
            {4'd0, 3'd1}: r = '{-CoefOne, CoefMinusTwoThirds, CoefZero};
            {4'd0, 3'd2}: r = '{CoefOne, CoefMinusTwoThirds, CoefZero};
            {4'd1, 3'd0}: r = '{CoefZero, CoefOne, -CoefOne};
            {4'd1, 3'd1}: r = '{-CoefOne, CoefZero, CoefOne};
            {4'd1, 3'd2}: r = '{CoefOne, CoefZero, CoefOne};
            {4'd1, 3'd3}: r = '{CoefZero, -CoefOne, -CoefOne};
            {4'd2, 3'd0}: r = '{-CoefOne, CoefOne, -CoefOne};
            {4'd2, 3'd1}: r = '{-CoefOne, -CoefOne, CoefOne};
            {4'd2, 3'd2}: r = '{CoefOne, CoefOne, CoefOne};
            {4'd2, 3'd3}: r = '{CoefOne, -CoefOne, -CoefOne};
            {4'd3, 3'd0}: r = '{CoefZero, CoefFourThirds, CoefOne};
            {4'd3, 3'd1}: r = '{-CoefOne, CoefMinusTwoThirds, -CoefOne};
            {4'd3, 3'd2}: r = '{CoefOne, CoefMinusTwoThirds, -CoefOne};
            {4'd3, 3'd3}: r = '{CoefZero, CoefFourThirds, -CoefOne};
            {4'd3, 3'd4}: r = '{-CoefOne, CoefMinusTwoThirds, CoefOne};
            {4'd3, 3'd5}: r = '{CoefOne, CoefMinusTwoThirds, CoefOne};
            {4'd4, 3'd0}: r = '{-CoefOne, CoefRoot3Half, CoefOne};
            {4'd4, 3'd1}: r = '{-CoefOne, -CoefRoot3Half, -CoefOne};
            {4'd4, 3'd2}: r = '{CoefOne, CoefRoot3Half, CoefOne};
            {4'd4, 3'd3}: r = '{CoefOne, -CoefRoot3Half, -CoefOne};
            {4'd4, 3'd4}: r = '{CoefZero, -CoefRoot3Half, CoefOne};
            {4'd4, 3'd5}: r = '{CoefZero, CoefRoot3Half, -CoefOne};
            {4'd5, 3'd0}: r = '{CoefZero, CoefOne, -CoefOne};
            {4'd5, 3'd1}: r = '{-CoefOne, -CoefOne, CoefZero};
            {4'd5, 3'd2}: r = '{CoefZero, CoefOne, CoefOne};
            {4'd5, 3'd3}: r = '{CoefOne, -CoefOne, CoefZero};
            {4'd6, 3'd0}: r = '{-CoefRoot3Half, CoefOne, CoefOne};
            {4'd6, 3'd1}: r = '{-CoefRoot3Half, -CoefOne, CoefOne};
            {4'd6, 3'd2}: r = '{CoefRoot3Half, CoefOne, -CoefOne};
            {4'd6, 3'd3}: r = '{CoefRoot3Half, -CoefOne, -CoefOne};
            {4'd6, 3'd4}: r = '{-CoefRoot3Half, CoefZero, -CoefOne};
            {4'd6, 3'd5}: r = '{CoefRoot3Half, CoefZero, CoefOne};
            {4'd7, 3'd0}: r = '{-CoefOne, CoefOne, -CoefOne};
            {4'd7, 3'd1}: r = '{-CoefOne, -CoefOne, CoefOne};
            {4'd7, 3'd2}: r = '{CoefOne, CoefOne, CoefOne};
            {4'd7, 3'd3}: r = '{CoefOne, -CoefOne, -CoefOne};
            {4'd7, 3'd4}: r = '{-CoefOne, CoefOne, CoefOne};
            {4'd7, 3'd5}: r = '{-CoefOne, -CoefOne, -CoefOne};
            {4'd7, 3'd6}: r = '{CoefOne, CoefOne, -CoefOne};
            {4'd7, 3'd7}: r = '{CoefOne, -CoefOne, CoefOne};
            {4'd8, 3'd0}: r = '{CoefRoot2Half, -CoefRoot2Half, CoefOne};
            {4'd8, 3'd1}: r = '{-CoefRoot2Half, -CoefRoot2Half, CoefOne};
            {4'd8, 3'd2}: r = '{-CoefRoot2Half, CoefRoot2Half, CoefOne};
            {4'd8, 3'd3}: r = '{CoefRoot2Half, CoefRoot2Half, CoefOne};
            {4'd8, 3'd4}: r = '{CoefZero, -CoefOne, -CoefOne};
            {4'd8, 3'd5}: r = '{-CoefOne, CoefZero, -CoefOne};
            {4'd8, 3'd6}: r = '{CoefZero, CoefOne, -CoefOne};
            {4'd8, 3'd7}: r = '{CoefOne, CoefZero, -CoefOne};
            {4'd9, 3'd0}: r = '{CoefOne, -CoefHalf, CoefOne};
            {4'd9, 3'd1}: r = '{-CoefHalf, -CoefOne, CoefOne};
            {4'd9, 3'd2}: r = '{-CoefOne, CoefHalf, CoefOne};
            {4'd9, 3'd3}: r = '{CoefHalf, CoefOne, CoefOne};
            {4'd9, 3'd4}: r = '{CoefHalf, -CoefOne, -CoefOne};
            {4'd9, 3'd5}: r = '{-CoefOne, -CoefHalf, -CoefOne};
            {4'd9, 3'd6}: r = '{-CoefHalf, CoefOne, -CoefOne};
            {4'd9, 3'd7}: r = '{CoefOne, CoefHalf, -CoefOne};
            {4'd10, 3'd0}: r = '{CoefZero, CoefOne, CoefOne};
            {4'd10, 3'd1}: r = '{-CoefOne, -CoefOne, CoefZero};
            {4'd10, 3'd2}: r = '{CoefZero, CoefOne, -CoefOne};
            {4'd10, 3'd3}: r = '{CoefOne, -CoefOne, CoefZero};
            {4'd11, 3'd0}: r = '{CoefFiveQuarters, CoefOne, CoefFiveQuarters};
            {4'd11, 3'd1}: r = '{-CoefOne, CoefZero, CoefOne};
            {4'd11, 3'd2}: r = '{CoefThreeQuarters, CoefOne, CoefThreeQuarters};
            {4'd11, 3'd3}: r = '{CoefOne, CoefZero, -CoefOne};
            {4'd11, 3'd4}: r = '{CoefFiveQuarters, -CoefOne, -CoefFiveQuarters};
            {4'd11, 3'd5}: r = '{CoefThreeQuarters, CoefOne, -CoefThreeQuarters};
            default: r = '{CoefZero, CoefZero, CoefZero};
         endcase
         case (sel)
            2'd0: row_coef = r[0];
            2'd1: row_coef = r[1];
            default: row_coef = r[2];
         endcase
      end
   endfunction

endpackage

// ===== hw/rtl/mmm_front.sv =====
module mmm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mmm_pkg::req_type      req_data,
   input  mmm_pkg::cfg_type      cfg,
   output logic                  frm_valid,
   input  logic                  frm_stall,
   output mmm_pkg::frame_type    frm_data
);

   logic                  valid_ff, valid_in;
   mmm_pkg::frame_type    data_ff, data_in;
   logic [mmm_pkg::MotorCountBits-1:0] count;
   logic signed [12:0]    stick_abs;
   logic signed [17:0]    lim;
   logic signed [17:0]    yaw_c;
   logic signed [17:0]    yaw_w;

   assign req_stall = valid_ff && frm_stall;
   assign frm_valid = valid_ff;
   assign frm_data = data_ff;

   // Classify: motor count, yaw clamp with sign applied, low stick flag.
   always_comb begin
      count = mmm_pkg::table_count(cfg.geometry);
      stick_abs = req_data.yaw_stick[11] ? -13'(req_data.yaw_stick)
                                         : 13'(req_data.yaw_stick);
      lim = 18'(stick_abs) + 18'sd100;
      yaw_w = 18'(req_data.yaw_corr);
      yaw_c = yaw_w;
      if (count > mmm_pkg::MotorCountBits'(3)) begin
         if (yaw_w < -lim) yaw_c = -lim;
         else if (yaw_w > lim) yaw_c = lim;
      end
      data_in.count = count;
      data_in.geometry = cfg.geometry;
      data_in.thr = req_data.throttle_demand;
      data_in.pitch = req_data.pitch_corr;
      data_in.roll = req_data.roll_corr;
      data_in.yaw = 18'(yaw_c * 18'(cfg.yaw_sign));
      data_in.low_stick = req_data.throttle_raw < cfg.throttle_check;
      data_in.armed = req_data.armed;
      valid_in = valid_ff && frm_stall;
      if (req_valid && !req_stall && count != '0) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && !req_stall) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hw/rtl/mmm_queue.sv =====
module mmm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  mmm_pkg::frame_type    in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output mmm_pkg::frame_type    out_data
);

   // Two entry queue between front and back.
   mmm_pkg::frame_type entry_ff [2];
   logic [1:0] fill_ff, fill_in;
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic       push, pop;

   assign in_stall = fill_ff == 2'd2;
   assign out_valid = fill_ff != 2'd0;
   assign out_data = entry_ff[rptr_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;

   always_comb begin
      fill_in = fill_ff + 2'(push) - 2'(pop);
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
      if (push) begin
         entry_ff[wptr_ff] <= in_data;
      end
   end

endmodule

// ===== hw/rtl/mmm_back.sv =====
module mmm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  frm_valid,
   output logic                  frm_stall,
   input  mmm_pkg::frame_type    frm_data,
   input  mmm_pkg::cfg_type      cfg,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mmm_pkg::rsp_type      rsp_data
);

   localparam int CB = mmm_pkg::CoefBits;
   localparam int Cnt = mmm_pkg::MotorCountBits;
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MIX = 2'd1;
   localparam logic [1:0] PH_EMIT = 2'd2;

   // Mix phase computes one motor a cycle; emit phase streams the results.
   logic [1:0]             phase_ff, phase_in;
   logic [Cnt-1:0]         idx_ff, idx_in;
   mmm_pkg::frame_type     frame_ff;
   logic signed [15:0]     level_ff [mmm_pkg::MaxRows];
   logic signed [15:0]     max_ff, max_in;
   logic                   ovalid_ff, ovalid_in;
   mmm_pkg::rsp_type       odata_ff, odata_in;
   logic [mmm_pkg::MotorIndexBits-1:0] m;
   logic signed [CB-1:0]   c_r, c_p, c_y;
   logic signed [CB+15:0]  p_r, p_p;
   logic signed [CB+17:0]  p_y;
   logic signed [CB+19:0]  acc;
   logic signed [CB+19:0]  q;
   logic signed [15:0]     sat;
   logic signed [16:0]     v, excess;
   logic                   take, load;

   assign m = idx_ff[mmm_pkg::MotorIndexBits-1:0];
   assign take = !ovalid_ff || !rsp_stall;
   assign load = phase_ff == PH_IDLE && frm_valid;
   assign frm_stall = !(phase_ff == PH_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_data = odata_ff;

   // Weighted sum of one motor row, truncated toward zero and saturated.
   always_comb begin
      c_r = mmm_pkg::row_coef(frame_ff.geometry, m, 2'd0);
      c_p = mmm_pkg::row_coef(frame_ff.geometry, m, 2'd1);
      c_y = mmm_pkg::row_coef(frame_ff.geometry, m, 2'd2);
      p_r = frame_ff.roll * c_r;
      p_p = frame_ff.pitch * c_p;
      p_y = frame_ff.yaw * c_y;
      acc = ((CB+20)'(frame_ff.thr) <<< mmm_pkg::CoefFraction)
          + (CB+20)'(p_r) + (CB+20)'(p_p) + (CB+20)'(p_y);
      q = (acc < 0) ? -((-acc) >>> mmm_pkg::CoefFraction)
                    : (acc >>> mmm_pkg::CoefFraction);
      if (q > 32767) sat = 16'sh7fff;
      else if (q < -32768) sat = -16'sh8000;
      else sat = 16'(q);
   end

   // Ceiling shift, clamp and overrides for the motor being emitted.
   always_comb begin
      excess = 17'(max_ff) - 17'($signed({1'b0, cfg.throttle_ceiling}));
      v = 17'(level_ff[m]);
      if (excess > 0) v = v - excess;
      if (v < 17'($signed({1'b0, cfg.throttle_floor}))) v = 17'(cfg.throttle_floor);
      else if (v > 17'($signed({1'b0, cfg.throttle_ceiling})))
         v = 17'(cfg.throttle_ceiling);
      if (frame_ff.low_stick) v = cfg.stop_on_low ? 17'(cfg.idle_command)
                                                  : 17'(cfg.throttle_floor);
      if (!frame_ff.armed) v = 17'(cfg.idle_command);
   end

   always_comb begin
      phase_in = phase_ff;
      idx_in = idx_ff;
      max_in = max_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      odata_in = odata_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (frm_valid) begin
               phase_in = PH_MIX;
               idx_in = '0;
            end
         end
         PH_MIX: begin
            if (idx_ff == '0 || sat > max_ff) max_in = sat;
            if (idx_ff == frame_ff.count - Cnt'(1)) begin
               phase_in = PH_EMIT;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + Cnt'(1);
            end
         end
         PH_EMIT: begin
            if (take) begin
               ovalid_in = 1'b1;
               odata_in.motor_number = m;
               odata_in.motor_level = 16'(v);
               odata_in.frame_end = idx_ff == frame_ff.count - Cnt'(1);
               if (odata_in.frame_end) phase_in = PH_IDLE;
               else idx_in = idx_ff + Cnt'(1);
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         ovalid_ff <= ovalid_in;
      end
      idx_ff <= idx_in;
      max_ff <= max_in;
      odata_ff <= odata_in;
      if (load) frame_ff <= frm_data;
      if (phase_ff == PH_MIX) level_ff[m] <= sat;
   end

endmodule

// ===== hw/rtl/multirotor_motor_mixer.sv =====
// Motor mixer: one control frame in, one item per motor out, motor order, with
// frame_end on the last. The front takes a frame each cycle unless stalled, and
// applies the yaw clamp; a two entry queue feeds the back, which mixes one motor
// per cycle with the geometry's fixed table and then streams the motors. Unknown
// geometries yield no items.
module multirotor_motor_mixer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mmm_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mmm_pkg::rsp_type    rsp_data,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [11:0]         csr_data
);

   mmm_pkg::cfg_type   cfg_ff, cfg_in;
   logic               f_valid, f_stall, b_valid, b_stall;
   mmm_pkg::frame_type f_data, b_data;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            mmm_pkg::CSR_GEOMETRY: cfg_in.geometry = csr_data[3:0];
            mmm_pkg::CSR_YAW_SIGN: cfg_in.yaw_sign = csr_data[1:0];
            mmm_pkg::CSR_FLOOR: cfg_in.throttle_floor = csr_data;
            mmm_pkg::CSR_CEILING: cfg_in.throttle_ceiling = csr_data;
            mmm_pkg::CSR_IDLE: cfg_in.idle_command = csr_data;
            mmm_pkg::CSR_CHECK: cfg_in.throttle_check = csr_data;
            mmm_pkg::CSR_STOP: cfg_in.stop_on_low = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.geometry <= 4'd2;
         cfg_ff.yaw_sign <= 2'sd1;
         cfg_ff.throttle_floor <= 12'd1150;
         cfg_ff.throttle_ceiling <= 12'd1850;
         cfg_ff.idle_command <= 12'd1000;
         cfg_ff.throttle_check <= 12'd1100;
         cfg_ff.stop_on_low <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mmm_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .cfg(cfg_ff),
      .frm_valid(f_valid), .frm_stall(f_stall), .frm_data(f_data)
   );

   mmm_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
   );

   mmm_back u_back (
      .clock(clock), .reset(reset),
      .frm_valid(b_valid), .frm_stall(b_stall), .frm_data(b_data),
      .cfg(cfg_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

// ===== bench/tb_multirotor_motor_mixer.sv =====
`timescale 1ns / 1ps

module tb_multirotor_motor_mixer;

   localparam int WatchdogLimit = 5000;
   localparam int DrainCycles = 40;
   localparam int PhaseItems = 18;
   localparam int Unit = 1000000;

   // Roll, pitch and yaw weights per motor in millionths; throttle is always one.
   localparam int MIX_TABLE [12][8][3] = '{
      '{'{0, 1333333, 0}, '{-Unit, -666667, 0}, '{Unit, -666667, 0},
        '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
      '{'{0, Unit, -Unit}, '{-Unit, 0, Unit}, '{Unit, 0, Unit}, '{0, -Unit, -Unit},
        '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
      '{'{-Unit, Unit, -Unit}, '{-Unit, -Unit, Unit}, '{Unit, Unit, Unit},
        '{Unit, -Unit, -Unit}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
      '{'{0, 1333333, Unit}, '{-Unit, -666667, -Unit}, '{Unit, -666667, -Unit},
        '{0, 1333333, -Unit}, '{-Unit, -666667, Unit}, '{Unit, -666667, Unit},
        '{0, 0, 0}, '{0, 0, 0}},
      '{'{-Unit, 866025, Unit}, '{-Unit, -866025, -Unit}, '{Unit, 866025, Unit},
        '{Unit, -866025, -Unit}, '{0, -866025, Unit}, '{0, 866025, -Unit},
        '{0, 0, 0}, '{0, 0, 0}},
      '{'{0, Unit, -Unit}, '{-Unit, -Unit, 0}, '{0, Unit, Unit}, '{Unit, -Unit, 0},
        '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
      '{'{-866025, Unit, Unit}, '{-866025, -Unit, Unit}, '{866025, Unit, -Unit},
        '{866025, -Unit, -Unit}, '{-866025, 0, -Unit}, '{866025, 0, Unit},
        '{0, 0, 0}, '{0, 0, 0}},
      '{'{-Unit, Unit, -Unit}, '{-Unit, -Unit, Unit}, '{Unit, Unit, Unit},
        '{Unit, -Unit, -Unit}, '{-Unit, Unit, Unit}, '{-Unit, -Unit, -Unit},
        '{Unit, Unit, -Unit}, '{Unit, -Unit, Unit}},
      '{'{707107, -707107, Unit}, '{-707107, -707107, Unit}, '{-707107, 707107, Unit},
        '{707107, 707107, Unit}, '{0, -Unit, -Unit}, '{-Unit, 0, -Unit},
        '{0, Unit, -Unit}, '{Unit, 0, -Unit}},
      '{'{Unit, -500000, Unit}, '{-500000, -Unit, Unit}, '{-Unit, 500000, Unit},
        '{500000, Unit, Unit}, '{500000, -Unit, -Unit}, '{-Unit, -500000, -Unit},
        '{-500000, Unit, -Unit}, '{Unit, 500000, -Unit}},
      '{'{0, Unit, Unit}, '{-Unit, -Unit, 0}, '{0, Unit, -Unit}, '{Unit, -Unit, 0},
        '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
      '{'{1250000, Unit, 1250000}, '{-Unit, 0, Unit}, '{750000, Unit, 750000},
        '{Unit, 0, -Unit}, '{1250000, -Unit, -1250000}, '{750000, Unit, -750000},
        '{0, 0, 0}, '{0, 0, 0}}
   };
   localparam int ROW_COUNT [12] = '{3, 4, 4, 6, 6, 4, 6, 8, 8, 8, 4, 6};

   typedef struct packed {
      mmm_pkg::req_type   item;
      logic               fixed;
      logic signed [15:0] level;
   } frame_row_type;

   localparam int DirectedRows = 15;
   localparam frame_row_type DIRECTED [DirectedRows] = '{
      '{'{12'd0, 16'sd0, 16'sd0, 16'sd0, 12'sd0, 12'd0, 1'b0}, 1'b1, 16'sd1000},
      '{'{12'd4095, 16'sd32767, 16'sd32767, 16'sd32767, 12'sd2047, 12'd4095, 1'b0},
        1'b1, 16'sd1000},
      '{'{12'd4095, -16'sd32768, -16'sd32768, -16'sd32768, -12'sd2048, 12'd0, 1'b0},
        1'b1, 16'sd1000},
      '{'{12'd1500, 16'sd100, -16'sd100, 16'sd50, 12'sd0, 12'd1099, 1'b1}, 1'b1, 16'sd1150},
      '{'{12'd0, 16'sd0, 16'sd0, 16'sd0, 12'sd0, 12'd0, 1'b1}, 1'b1, 16'sd1150},
      '{'{12'd0, 16'sd0, 16'sd0, 16'sd0, 12'sd0, 12'd4095, 1'b1}, 1'b1, 16'sd1150},
      '{'{12'd4095, 16'sd0, 16'sd0, 16'sd0, 12'sd0, 12'd4095, 1'b1}, 1'b1, 16'sd1850},
      '{'{12'd1500, 16'sd0, 16'sd0, 16'sd0, 12'sd0, 12'd2000, 1'b1}, 1'b1, 16'sd1500},
      '{'{12'd4095, 16'sd32767, 16'sd32767, 16'sd32767, 12'sd2047, 12'd4095, 1'b1},
        1'b0, 16'sd0},
      '{'{12'd4095, -16'sd32768, -16'sd32768, -16'sd32768, -12'sd2048, 12'd4095, 1'b1},
        1'b0, 16'sd0},
      '{'{12'd0, 16'sd32767, -16'sd32768, 16'sd32767, -12'sd2048, 12'd4095, 1'b1},
        1'b0, 16'sd0},
      '{'{12'd1500, 16'sd0, 16'sd0, 16'sd5000, 12'sd300, 12'd2000, 1'b1}, 1'b0, 16'sd0},
      '{'{12'd1500, 16'sd0, 16'sd0, -16'sd5000, -12'sd2048, 12'd2000, 1'b1}, 1'b0, 16'sd0},
      '{'{12'd1500, 16'sd200, -16'sd300, 16'sd100, 12'sd0, 12'd1100, 1'b1}, 1'b0, 16'sd0},
      '{'{12'd1400, -16'sd50, 16'sd60, -16'sd70, 12'sd10, 12'd2000, 1'b1}, 1'b0, 16'sd0}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   mmm_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   mmm_pkg::rsp_type rsp_data;
   logic             csr_write;
   logic [2:0]       csr_index;
   logic [11:0]      csr_data;

   // Local copy of the register file.
   int geometry_reg = 2;
   int yaw_sign_reg = 1;
   int floor_reg = 1150;
   int ceiling_reg = 1850;
   int idle_reg = 1000;
   int check_reg = 1100;
   int stop_reg = 0;

   mmm_pkg::rsp_type motor_q[$];
   int      mismatches = 0;
   int      stall_free_cycles = 0;
   bit      quiet = 0;

   multirotor_motor_mixer u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Decimal weight to Q.CoefFraction, rounded half away from zero.
   function automatic longint weight_q(input int micro);
      longint mag;
      longint q;
      begin
         mag = (micro < 0) ? -longint'(micro) : longint'(micro);
         q = (mag * (longint'(1) << mmm_pkg::CoefFraction) + 500000) / 1000000;
         weight_q = (micro < 0) ? -q : q;
      end
   endfunction

   // Mix one frame and queue the motor items it should produce.
   task automatic mix_frame(input mmm_pkg::req_type r);
      longint  level [8];
      longint  acc;
      longint  yaw;
      longint  span;
      longint  top;
      int      n;
      int      v;
      mmm_pkg::rsp_type m;
      begin
         if (geometry_reg < mmm_pkg::NumGeometries) begin
            n = ROW_COUNT[geometry_reg];
            if (n > mmm_pkg::MotorLimit) n = mmm_pkg::MotorLimit;
            yaw = r.yaw_corr;
            if (n > 3) begin
               span = 100 + ((r.yaw_stick < 0) ? -longint'(r.yaw_stick) : r.yaw_stick);
               if (yaw < -span) yaw = -span;
               else if (yaw > span) yaw = span;
            end
            for (int i = 0; i < n; i++) begin
               acc = longint'(r.throttle_demand) * weight_q(Unit)
                   + longint'(r.roll_corr) * weight_q(MIX_TABLE[geometry_reg][i][0])
                   + longint'(r.pitch_corr) * weight_q(MIX_TABLE[geometry_reg][i][1])
                   + yaw_sign_reg * yaw * weight_q(MIX_TABLE[geometry_reg][i][2]);
               acc = acc / (longint'(1) << mmm_pkg::CoefFraction);
               if (acc > 32767) acc = 32767;
               if (acc < -32768) acc = -32768;
               level[i] = acc;
            end
            top = level[0];
            for (int i = 1; i < n; i++) if (level[i] > top) top = level[i];
            for (int i = 0; i < n; i++) begin
               v = int'(level[i]);
               if (top > ceiling_reg) v -= int'(top) - ceiling_reg;
               // Floor is tested first, so it wins when above the ceiling.
               if (v < floor_reg) v = floor_reg;
               else if (v > ceiling_reg) v = ceiling_reg;
               if (r.throttle_raw < check_reg) v = stop_reg ? idle_reg : floor_reg;
               if (!r.armed) v = idle_reg;
               m.motor_number = 3'(i);
               m.motor_level = 16'(v);
               m.frame_end = (i == n - 1);
               motor_q.push_back(m);
            end
         end
      end
   endtask

   task automatic set_reg(input logic [2:0] idx, input int value);
      begin
         csr_write = 1'b1;
         csr_index = idx;
         csr_data = 12'(value);
         @(negedge clock);
         csr_write = 1'b0;
         case (idx)
            mmm_pkg::CSR_GEOMETRY: geometry_reg = value & 15;
            mmm_pkg::CSR_YAW_SIGN:
               yaw_sign_reg = (value & 2) ? (value & 3) - 4 : (value & 3);
            mmm_pkg::CSR_FLOOR:    floor_reg = value & 12'hfff;
            mmm_pkg::CSR_CEILING:  ceiling_reg = value & 12'hfff;
            mmm_pkg::CSR_IDLE:     idle_reg = value & 12'hfff;
            mmm_pkg::CSR_CHECK:    check_reg = value & 12'hfff;
            default:               stop_reg = value & 1;
         endcase
      end
   endtask

   // Present one item, hold it until accepted, then predict its motors.
   task automatic send_frame(input mmm_pkg::req_type r);
      begin
         while (!quiet && $urandom_range(99) < 11) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
         req_valid = 1'b1;
         req_data = r;
         do @(posedge clock); while (req_stall);
         mix_frame(r);
         @(negedge clock);
      end
   endtask

   // Wait for every motor item, then let a frame with no items clear out.
   task automatic drain;
      begin
         req_valid = 1'b0;
         while (motor_q.size() != 0) @(negedge clock);
         repeat (DrainCycles) @(negedge clock);
      end
   endtask

   function automatic logic signed [15:0] rand_corr;
      begin
         if ($urandom_range(99) < 70) rand_corr = 16'($signed($urandom_range(1200)) - 600);
         else rand_corr = 16'($urandom);
      end
   endfunction

   // Main stimulus: directed rows, then one phase per geometry with random frames.
   initial begin
      mmm_pkg::req_type r;
      mmm_pkg::rsp_type m;
      int      n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = mmm_pkg::CSR_GEOMETRY;
      csr_data = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < DirectedRows; k++) begin
         if (DIRECTED[k].fixed) begin
            send_frame(DIRECTED[k].item);
            // Replace the prediction with the value read off the reset settings.
            n = ROW_COUNT[geometry_reg];
            repeat (n) void'(motor_q.pop_back());
            for (int i = 0; i < n; i++) begin
               m.motor_number = 3'(i);
               m.motor_level = DIRECTED[k].level;
               m.frame_end = (i == n - 1);
               motor_q.push_back(m);
            end
         end else begin
            send_frame(DIRECTED[k].item);
         end
      end
      drain();

      for (int p = 0; p < 16; p++) begin
         set_reg(mmm_pkg::CSR_GEOMETRY, p);
         case (p % 4)
            0: set_reg(mmm_pkg::CSR_YAW_SIGN, 1);
            1: set_reg(mmm_pkg::CSR_YAW_SIGN, 3);
            2: set_reg(mmm_pkg::CSR_YAW_SIGN, 0);
            default: set_reg(mmm_pkg::CSR_YAW_SIGN, 2);
         endcase
         case (p)
            3: begin
               // Floor above the ceiling.
               set_reg(mmm_pkg::CSR_FLOOR, 2000);
               set_reg(mmm_pkg::CSR_CEILING, 1000);
               set_reg(mmm_pkg::CSR_IDLE, $urandom_range(4095));
               set_reg(mmm_pkg::CSR_CHECK, 1000);
            end
            5: begin
               set_reg(mmm_pkg::CSR_FLOOR, 0);
               set_reg(mmm_pkg::CSR_CEILING, 4095);
               set_reg(mmm_pkg::CSR_IDLE, 0);
               set_reg(mmm_pkg::CSR_CHECK, 0);
            end
            9: begin
               set_reg(mmm_pkg::CSR_FLOOR, 4095);
               set_reg(mmm_pkg::CSR_CEILING, 4095);
               set_reg(mmm_pkg::CSR_IDLE, 4095);
               set_reg(mmm_pkg::CSR_CHECK, 4095);
            end
            default: begin
               set_reg(mmm_pkg::CSR_FLOOR, $urandom_range(1300, 1000));
               set_reg(mmm_pkg::CSR_CEILING, $urandom_range(2000, 1700));
               set_reg(mmm_pkg::CSR_IDLE, $urandom_range(4095));
               set_reg(mmm_pkg::CSR_CHECK, $urandom_range(1300, 900));
            end
         endcase
         set_reg(mmm_pkg::CSR_STOP, p % 2);
         quiet = (p >= 6 && p <= 8);

         for (int k = 0; k < PhaseItems; k++) begin
            r.throttle_demand = ($urandom_range(99) < 80) ? 12'($urandom_range(2100, 900))
                                                          : 12'($urandom);
            r.pitch_corr = rand_corr();
            r.roll_corr = rand_corr();
            r.yaw_corr = rand_corr();
            r.yaw_stick = 12'($urandom);
            r.throttle_raw = ($urandom_range(99) < 85) ? 12'($urandom_range(2100, 1000))
                                                       : 12'($urandom);
            r.armed = ($urandom_range(99) < 90);
            send_frame(r);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("[multirotor_motor_mixer] OK");
      end else begin
         $display("[multirotor_motor_mixer] ERROR");
      end
      $finish;
   end

   // Result side: random stall, set on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= !quiet && !reset && ($urandom_range(99) < 11);
   end

   initial rsp_stall = 1'b0;

   // Compare each accepted motor item with the oldest prediction; watch for a hang.
   always @(posedge clock) begin
      mmm_pkg::rsp_type want;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stall_free_cycles <= 0;
      end else begin
         stall_free_cycles <= stall_free_cycles + 1;
      end
      if (stall_free_cycles >= WatchdogLimit) begin
         $display("[multirotor_motor_mixer] ERROR");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (motor_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected motor item %p", rsp_data);
         end else begin
            want = motor_q.pop_front();
            if (rsp_data.motor_number !== want.motor_number
                || rsp_data.motor_level !== want.motor_level
                || rsp_data.frame_end !== want.frame_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("motor item mismatch: expected num %0d level %0d end %0b,",
                           want.motor_number, want.motor_level, want.frame_end,
                           " got num %0d level %0d end %0b",
                           rsp_data.motor_number, rsp_data.motor_level,
                           rsp_data.frame_end);
            end
         end
      end
   end

endmodule
